@@ design/strmq_pkg.sv @@
`default_nettype none
package strmq_pkg;
  localparam int MAX_ELEMENTS = 1024;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_BUILD_L0,
    ST_BUILD_RD,
    ST_BUILD_RV,
    ST_BUILD_CMP,
    ST_QRY_RT,
    ST_QRY_WT,
    ST_QRY_RV,
    ST_QRY_WV,
    ST_QRY_OUT
  } state_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [0:0] REG_SELECT_MAX    = 1'b0;
  localparam logic [0:0] REG_ELEMENT_COUNT = 1'b1;

  // True if x beats y under the selected order (strict)
  function automatic logic beats(input logic signed [63:0] x,
                                 input logic signed [63:0] y,
                                 input logic sel_max);
    beats = sel_max ? (x > y) : (x < y);
  endfunction
endpackage
`default_nettype wire

@@ design/sparse_table_range_min_max_top.sv @@
`default_nettype none
// Range minimum/maximum query over a sparse table held in two RAMs with one
// registered read port each (elements and winner indices). After reset a
// clearing pass zeroes the element RAM; no word is accepted meanwhile. A write
// word is stored in the write state that follows acceptance. A query on a
// current table steps through a decode state, two spans (winner-table read,
// then element read, serialized on one read port each) and an output state. A
// query on a stale table first rebuilds it: level 0, then each entry of the
// upper levels from both winners read through the one read port of each RAM.
// Any write of a word or register marks the table stale. A bad range skips
// the table and answers with range_error set and a zero value. No word is
// taken while a result waits.
module sparse_table_range_min_max_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [9:0]  in_position,
  input  wire logic signed [63:0] in_value,
  input  wire logic [9:0]  in_range_start,
  input  wire logic [10:0] in_range_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [63:0] out_extreme_value,
  output logic             out_range_error
);
  import strmq_pkg::*;

  localparam int AW   = $clog2(MAX_ELEMENTS);
  localparam int CW   = AW + 1;
  localparam int LV   = AW + 1;
  localparam int LW   = (LV > 1) ? $clog2(LV) : 1;
  localparam int TD   = LV * MAX_ELEMENTS;
  localparam int TAW  = $clog2(TD);
  localparam logic [CW-1:0] MAXC = CW'(MAX_ELEMENTS);

  // Registers
  state_t          state_r, state_nxt;
  logic            sel_max_r;
  logic [CW-1:0]   count_r;
  logic            current_r;
  logic [CW-1:0]   j_r, j_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;
  logic [LW-1:0]   top_r;
  logic [1:0]      ph_r, ph_nxt;
  logic [AW-1:0]   wa_r, wa_nxt;
  logic signed [63:0] va_r, va_nxt;
  logic [AW-1:0]   qs_r, qe_r;
  logic [LW-1:0]   qk_r;
  logic            out_valid_r;
  logic signed [63:0] out_val_r;
  logic            out_err_r;
  logic            cmd_r;
  logic [AW-1:0]   pos_r;
  logic signed [63:0] wval_r;
  logic [9:0]      rs_r;
  logic [10:0]     re_r;
  logic [AW-1:0]   pos_b_r;
  logic [AW-1:0]   rv_idx_r;

  // RAM ports
  logic             e_we, t_we;
  logic [AW-1:0]    e_waddr, e_raddr;
  logic [63:0]      e_wdata, e_rdata;
  logic [TAW-1:0]   t_waddr, t_raddr;
  logic [AW-1:0]    t_wdata, t_rdata;

  strmq_ram #(.WIDTH(64), .DEPTH(MAX_ELEMENTS)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );
  strmq_ram #(.WIDTH(AW), .DEPTH(TD)) u_tab (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  function automatic logic [LW-1:0] flog2(input logic [CW-1:0] v);
    logic [LW-1:0] k;
    k = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) k = LW'(i);
    end
    return k;
  endfunction

  function automatic logic [TAW-1:0] taddr(input logic [LW-1:0] l,
                                           input logic [AW-1:0] j);
    return TAW'(l) * TAW'(MAX_ELEMENTS) + TAW'(j);
  endfunction

  // Query decode on the held word
  logic [CW-1:0] qlen;
  logic          bad_range;
  logic [LW-1:0] qk;
  logic [CW-1:0] qw;
  always_comb begin
    qlen = CW'(re_r) - CW'(rs_r);
    bad_range = ({1'b0, rs_r} >= re_r) || ({1'b0, re_r} > {1'b0, 11'(count_r)}) ||
                (count_r == '0);
    qk = flog2(qlen);
    qw = CW'(1) << qk;
  end

  logic [CW-1:0] wspan;
  assign wspan = CW'(1) << lvl_r;
  logic signed [63:0] e_sval;
  assign e_sval = e_rdata;

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (j_r == MAXC - CW'(1)) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid && in_ready) state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (cmd_r == CMD_WRITE) state_nxt = ST_IDLE;
        else if (bad_range) state_nxt = ST_QRY_OUT;
        else if (!current_r) state_nxt = ST_BUILD_L0;
        else state_nxt = ST_QRY_RT;
      end
      ST_BUILD_L0: begin
        if (j_r == count_r - CW'(1)) begin
          state_nxt = (top_r == '0) ? ST_QRY_RT : ST_BUILD_RD;
        end
      end
      ST_BUILD_RD:  state_nxt = ST_BUILD_RV;
      ST_BUILD_RV:  state_nxt = (ph_r == 2'd1) ? ST_BUILD_CMP : ST_BUILD_RD;
      ST_BUILD_CMP: begin
        if (ph_r == 2'd3) begin
          if (j_r + (wspan << 1) + CW'(1) > count_r) begin
            state_nxt = (lvl_r + LW'(1) == top_r) ? ST_QRY_RT : ST_BUILD_RD;
          end else begin
            state_nxt = ST_BUILD_RD;
          end
        end
      end
      ST_QRY_RT:  state_nxt = ST_QRY_WT;
      ST_QRY_WT:  state_nxt = ST_QRY_RV;
      ST_QRY_RV:  state_nxt = ST_QRY_WV;
      ST_QRY_WV:  state_nxt = (ph_r == 2'd1) ? ST_QRY_OUT : ST_QRY_RT;
      ST_QRY_OUT: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and RAM addressing
  always_comb begin
    e_we = 1'b0; e_waddr = pos_r; e_wdata = wval_r; e_raddr = wa_r;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
    j_nxt = j_r; lvl_nxt = lvl_r; ph_nxt = ph_r; wa_nxt = wa_r; va_nxt = va_r;
    unique case (state_r)
      ST_CLEAR: begin
        e_we = 1'b1; e_waddr = j_r[AW-1:0]; e_wdata = '0;
        j_nxt = j_r + CW'(1);
      end
      ST_IDLE: begin
        j_nxt = '0; lvl_nxt = '0; ph_nxt = '0;
      end
      ST_WRITE: begin
        e_we = (cmd_r == CMD_WRITE);
        j_nxt = '0; lvl_nxt = '0; ph_nxt = '0;
      end
      ST_BUILD_L0: begin
        t_we = 1'b1; t_waddr = taddr('0, j_r[AW-1:0]); t_wdata = j_r[AW-1:0];
        j_nxt = j_r + CW'(1);
        if (j_r == count_r - CW'(1)) j_nxt = '0;
      end
      ST_BUILD_RD: begin
        // read winner a (ph 0) or b (ph 1) of level lvl
        t_raddr = taddr(lvl_r, (ph_r == 2'd0) ? j_r[AW-1:0]
                                              : AW'(j_r + wspan));
      end
      ST_BUILD_RV: begin
        e_raddr = t_rdata;
        if (ph_r == 2'd0) wa_nxt = t_rdata;
        else va_nxt = e_sval;  // value of a is still on the read port
        ph_nxt = ph_r + 2'd1;
      end
      ST_BUILD_CMP: begin
        if (ph_r == 2'd2) begin
          // value of b arrives
          ph_nxt = 2'd3;
        end else begin
          ph_nxt = '0;
          t_we = 1'b1;
          t_waddr = taddr(lvl_r + LW'(1), j_r[AW-1:0]);
          t_wdata = beats(va_r, out_val_r, sel_max_r) ? wa_r : pos_b_r;
          j_nxt = j_r + CW'(1);
          if (j_r + (wspan << 1) + CW'(1) > count_r) begin
            j_nxt = '0; lvl_nxt = lvl_r + LW'(1);
          end
        end
      end
      ST_QRY_RT, ST_QRY_WT: t_raddr = taddr(qk_r, (ph_r == 2'd0) ? qs_r : qe_r);
      ST_QRY_RV: begin
        e_raddr = t_rdata;
        if (ph_r == 2'd0) wa_nxt = t_rdata;
      end
      ST_QRY_WV: begin
        if (ph_r == 2'd0) va_nxt = e_sval;
        ph_nxt = ph_r + 2'd1;
      end
      ST_QRY_OUT: ;
      default: ;
    endcase
  end

  // Winner b index/value for build compare; query result, zero on error
  always_ff @(posedge clk) begin
    if (state_r == ST_BUILD_RV) rv_idx_r <= t_rdata;
    if (state_r == ST_BUILD_CMP && ph_r == 2'd2) begin
      pos_b_r   <= rv_idx_r;
      out_val_r <= e_sval;
    end else if (state_r == ST_QRY_WV && ph_r == 2'd1) begin
      out_val_r <= beats(va_r, e_sval, sel_max_r) ? va_r : e_sval;
    end else if (state_r == ST_WRITE && cmd_r == CMD_QUERY && bad_range) begin
      out_val_r <= '0;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command; pos_r <= in_position[AW-1:0]; wval_r <= in_value;
      rs_r <= in_range_start; re_r <= in_range_end;
    end
    if (state_r == ST_WRITE) begin
      qs_r <= rs_r[AW-1:0];
      qe_r <= AW'(CW'(re_r) - qw);
      qk_r <= qk;
      out_err_r <= bad_range;
      top_r <= flog2(count_r);
    end
    wa_r <= wa_nxt;
    va_r <= va_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; j_r <= '0; lvl_r <= '0; ph_r <= '0;
      sel_max_r <= 1'b0; count_r <= MAXC; current_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; j_r <= j_nxt; lvl_r <= lvl_nxt; ph_r <= ph_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SELECT_MAX: sel_max_r <= cfg_data[0];
          REG_ELEMENT_COUNT: begin
            count_r <= ({1'b0, cfg_data} > 12'(MAX_ELEMENTS)) ? MAXC
                                                               : CW'(cfg_data);
          end
          default: ;
        endcase
        current_r <= 1'b0;
      end else if (state_r == ST_WRITE && cmd_r == CMD_WRITE) begin
        current_r <= 1'b0;
      end else if (state_r == ST_QRY_RT) begin
        current_r <= 1'b1;
      end
      if (state_r == ST_QRY_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_extreme_value = out_err_r ? 64'sd0 : out_val_r;
  assign out_range_error = out_err_r;

`ifndef ASSERT_OFF
  // No new word while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  // An error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_extreme_value == 64'sd0)
    else $error("error result with nonzero value");
  // Result appears in the cycle after the last query step
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_QRY_OUT))
    else $error("result without query");
`endif
endmodule
`default_nettype wire

@@ design/strmq_ram.sv @@
`default_nettype none
module strmq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import strmq_pkg::*;

  typedef struct {
    logic              cmd;
    logic [9:0]        pos;
    logic signed [63:0] val;
    logic [9:0]        rs;
    logic [10:0]       re;
    bit                known;
    logic signed [63:0] known_val;
    logic              known_err;
  } stim_row_t;

  typedef struct {
    logic signed [63:0] val;
    logic              err;
  } range_answer_t;

  localparam logic signed [63:0] MIN_S64 = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MAX_S64 = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic [9:0] in_position = '0;
  logic signed [63:0] in_value = '0;
  logic [9:0] in_range_start = '0;
  logic [10:0] in_range_end = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] out_extreme_value;
  logic out_range_error;

  sparse_table_range_min_max_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_position(in_position), .in_value(in_value),
    .in_range_start(in_range_start), .in_range_end(in_range_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_extreme_value(out_extreme_value), .out_range_error(out_range_error)
  );

  // shadow state of the block
  logic signed [63:0] elem_mem [1024];
  bit                 pick_max;
  logic [10:0]        count_reg;
  range_answer_t      answer_q[$];
  int                 mismatches = 0;
  bit                 quiet = 0;
  bit                 hold_req = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 10_000_000);
    $display("sparse_table_range_min_max_top: mismatch");
    $finish;
  end

  function automatic int live_count();
    return (count_reg > 11'd1024) ? 1024 : int'(count_reg);
  endfunction

  // extreme over [rs, re), or an error for a bad range
  function automatic range_answer_t range_extreme(logic [9:0] rs, logic [10:0] re);
    range_answer_t r;
    r.val = '0;
    r.err = 1'b1;
    if (rs < re && int'(re) <= live_count()) begin
      r.err = 1'b0;
      r.val = elem_mem[rs];
      for (int i = rs + 1; i < re; i++)
        if (pick_max ? (elem_mem[i] > r.val) : (elem_mem[i] < r.val)) r.val = elem_mem[i];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return MIN_S64;
      1: return MAX_S64;
      2: return 64'(signed'($urandom_range(0, 6)) - 3);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one word and hold it until accepted; update the shadow state
  task automatic send_word(stim_row_t w);
    int gap;
    range_answer_t a;
    in_valid <= 1'b1;
    in_command <= w.cmd;
    in_position <= w.pos;
    in_value <= w.val;
    in_range_start <= w.rs;
    in_range_end <= w.re;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.cmd == CMD_WRITE) begin
      elem_mem[w.pos] = w.val;
    end else begin
      a = range_extreme(w.rs, w.re);
      if (w.known) begin
        a.val = w.known_val;
        a.err = w.known_err;
      end
      answer_q = {answer_q, a};
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait until every answer is back
  task automatic drain();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [10:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SELECT_MAX) pick_max = data[0];
    else count_reg = data;
  endtask

  function automatic stim_row_t wr(int p, logic signed [63:0] v);
    stim_row_t s;
    s = '{CMD_WRITE, 10'(p), v, 10'd0, 11'd0, 0, 64'sd0, 1'b0};
    return s;
  endfunction

  function automatic stim_row_t qry(int rs, int re, bit k = 0,
                                    logic signed [63:0] kv = 0, logic ke = 0);
    stim_row_t s;
    s = '{CMD_QUERY, 10'($urandom), {$urandom, $urandom}, 10'(rs), 11'(re), k, kv, ke};
    return s;
  endfunction

  // random word: mostly valid queries and in-count writes
  function automatic stim_row_t rand_word();
    int n;
    int rs;
    int re;
    n = live_count();
    case ($urandom_range(0, 9))
      0, 1, 2: return wr((n > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, n - 1)
                                                               : $urandom_range(0, 1023),
                         rand_value());
      3: return qry($urandom_range(0, 1023), $urandom_range(0, 1024));
      default: begin
        if (n == 0) return qry(0, 1);
        rs = $urandom_range(0, n - 1);
        re = $urandom_range(rs + 1, n);
        return qry(rs, re);
      end
    endcase
  endfunction

  // receiver: check answers, stall in bursts, one long hold-off on request
  initial begin
    int stall_left;
    range_answer_t e;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected answer: value %0d error %0b", out_extreme_value,
                     out_range_error);
        end else begin
          e = answer_q.pop_front();
          if (e.val !== out_extreme_value || e.err !== out_range_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("answer mismatch: expected %0d/%0b got %0d/%0b", e.val, e.err,
                       out_extreme_value, out_range_error);
          end
        end
      end
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  stim_row_t opening [] = '{
    qry(0, 1024, 1, 64'sd0, 1'b0),
    qry(0, 0, 1, 64'sd0, 1'b1),
    qry(5, 3, 1, 64'sd0, 1'b1),
    qry(1023, 1025, 1, 64'sd0, 1'b1),
    wr(0, MIN_S64),
    wr(1023, MAX_S64),
    wr(512, -64'sd1),
    wr(513, -64'sd1),
    qry(0, 1024, 1, MIN_S64, 1'b0),
    qry(1023, 1024, 1, MAX_S64, 1'b0),
    qry(512, 514, 1, -64'sd1, 1'b0),
    qry(1, 1023),
    qry(300, 700),
    qry(511, 513)
  };

  stim_row_t max_rows [] = '{
    qry(0, 1024, 1, MAX_S64, 1'b0),
    qry(0, 1, 1, MIN_S64, 1'b0),
    qry(400, 600),
    qry(2, 1024)
  };

  initial begin
    stim_row_t w;
    int items;
    for (int i = 0; i < 1024; i++) elem_mem[i] = '0;
    pick_max = 0;
    count_reg = 11'd1024;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, mostly at full count
    foreach (opening[i]) send_word(opening[i]);
    write_reg(REG_SELECT_MAX, 11'd1);
    foreach (max_rows[i]) send_word(max_rows[i]);
    write_reg(REG_ELEMENT_COUNT, 11'd0);
    send_word(qry(0, 1, 1, 64'sd0, 1'b1));
    write_reg(REG_ELEMENT_COUNT, 11'd2047);
    send_word(qry(0, 1024, 1, MAX_S64, 1'b0));
    send_word(wr(20, 64'sd5));

    // random phases, small counts keep rebuilds short
    for (int ph = 0; ph < 13; ph++) begin
      write_reg(REG_SELECT_MAX, 11'($urandom_range(0, 1)));
      case (ph % 4)
        0: write_reg(REG_ELEMENT_COUNT, 11'd1);
        1: write_reg(REG_ELEMENT_COUNT, 11'd2);
        default: write_reg(REG_ELEMENT_COUNT, 11'($urandom_range(3, 20)));
      endcase
      if (ph == 12) quiet = 1;
      if (ph == 5) hold_req = 1;
      items = 0;
      while (items < 125) begin
        w = rand_word();
        send_word(w);
        items++;
      end
    end

    // queries only at full count: one rebuild, many lookups
    write_reg(REG_ELEMENT_COUNT, 11'd1024);
    for (int i = 0; i < 60; i++) begin
      w = rand_word();
      if (w.cmd == CMD_WRITE) w = qry(0, 1024);
      send_word(w);
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("sparse_table_range_min_max_top: match");
    end else begin
      $display("sparse_table_range_min_max_top: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
